// ===== rtl/core/oafr_pkg.sv =====
`timescale 1ns / 1ps

package oafr_pkg;

    // Item kinds carried in the input tuser
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Configuration register indexes
    localparam logic REG_CHANNELS = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    // Field widths
    localparam int SAMPLE_W  = 24;
    localparam int CH_W      = 4;
    localparam int CAP_W     = 14;
    localparam int REQ_W     = 4;
    localparam int FRAMES_W  = 14;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 48;

    // Channel count limits and register reset values
    localparam logic [CH_W-1:0]  MAX_CHANNELS = 4'd8;
    localparam logic [CH_W-1:0]  CH_RESET     = 4'd2;
    localparam logic [CAP_W-1:0] CAP_RESET    = 14'd8192;

    // Per-result side information
    typedef struct packed {
        logic                sample_valid;
        logic                last_of_read;
        logic [REQ_W-1:0]    frames_read;
        logic [FRAMES_W-1:0] frames_buffered;
        logic                stream_finished;
    } t_meta;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

endpackage

// ===== rtl/core/overwriting_audio_frame_ring.sv =====
// Push and finish items are accepted in the idle state; the input is ready again next cycle.
// A read item of N samples holds the input while its reads issue: one memory read per
// cycle on the single read port unless the output stalls; an empty read is one bubble.
// Results pass the memory-output and output registers; one per cycle when not stalled.
// Reset (synchronous, active low) empties the ring, clears the finished flag and loads
// 2 channels / 8192 samples; the sample memory is not cleared.
`timescale 1ns / 1ps

module overwriting_audio_frame_ring #(
    parameter int DEPTH           = 8192,
    parameter int MAX_READ_FRAMES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [23:0] push_sample, [27:24] frame_request, [31:28] zero
    input  logic [oafr_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] op
    input  logic [1:0]                        i_s_axis_tuser,
    // end_of_packet
    input  logic                              i_s_axis_tlast,
    // Result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [23:0] read_sample, [27:24] frames_read, [41:28] frames_buffered,
    // [42] stream_finished, [47:43] zero
    output logic [oafr_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // [0] sample_valid
    output logic                              o_m_axis_tuser,
    // last_of_read
    output logic                              o_m_axis_tlast,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [oafr_pkg::CAP_W-1:0]        i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > oafr_pkg::CAP_W) ? FW : oafr_pkg::CAP_W;
    localparam int RW = $clog2(MAX_READ_FRAMES + 1);
    localparam int QW = (RW > oafr_pkg::REQ_W) ? RW : oafr_pkg::REQ_W;
    localparam int NW = (FW > RW) ? FW : RW;
    localparam int SW = RW + oafr_pkg::CH_W;

    // Sample memory
    logic signed [oafr_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [oafr_pkg::SAMPLE_W-1:0] r_rd_data;
    logic                                 mem_we;
    logic                                 mem_re;

    // Ring state
    oafr_pkg::t_state            r_state, n_state;
    logic [oafr_pkg::CH_W-1:0]   r_ch;
    logic [oafr_pkg::CAP_W-1:0]  r_cap;
    logic [AW-1:0]               r_rd_idx, n_rd_idx;
    logic [AW-1:0]               r_wr_idx, n_wr_idx;
    logic [FW-1:0]               r_fill, n_fill;
    logic [FW-1:0]               r_avail, n_avail;
    logic [2:0]                  r_rem, n_rem;
    logic                        r_finished, n_finished;

    // Read sequencing
    logic [SW-1:0]               r_left, n_left;
    logic                        r_bubble, n_bubble;
    oafr_pkg::t_meta             r_tmpl, n_tmpl;
    oafr_pkg::t_meta             issue_meta;

    // Memory-output stage and output register
    logic                        r_m_valid;
    oafr_pkg::t_meta             r_m_meta;
    logic                        r_out_valid;
    oafr_pkg::t_meta             r_out_meta;
    logic signed [oafr_pkg::SAMPLE_W-1:0] r_out_sample;

    // Decoded values
    logic [CW-1:0]               cap_w;
    logic [FW-1:0]               cap_eff;
    logic [oafr_pkg::CH_W-1:0]   ch_eff;
    logic [QW-1:0]               req_w;
    logic [RW-1:0]               req_sat;
    logic [RW-1:0]               frames;
    logic [SW-1:0]               samples;
    logic [FW-1:0]               after;
    logic [FW-1:0]               rd_inc, wr_inc;
    logic [AW-1:0]               rd_next, wr_next;
    logic                        in_xfer;
    logic                        out_ready;
    logic                        issue;
    logic [1:0]                  op;

    assign op = i_s_axis_tuser;

    // Effective configuration
    always_comb begin
        cap_w = CW'(r_cap);
        if (r_cap == '0) begin
            cap_eff = FW'(1);
        end else if (cap_w > CW'(DEPTH)) begin
            cap_eff = FW'(DEPTH);
        end else begin
            cap_eff = FW'(cap_w);
        end
        if (r_ch == '0) begin
            ch_eff = oafr_pkg::CH_W'(1);
        end else if (r_ch > oafr_pkg::MAX_CHANNELS) begin
            ch_eff = oafr_pkg::MAX_CHANNELS;
        end else begin
            ch_eff = r_ch;
        end
    end

    // Read sizing: frames granted, samples and frames left afterwards
    always_comb begin
        req_w   = QW'(i_s_axis_tdata[27:24]);
        req_sat = (req_w > QW'(MAX_READ_FRAMES)) ? RW'(MAX_READ_FRAMES) : RW'(req_w);
        frames  = (NW'(r_avail) < NW'(req_sat)) ? RW'(r_avail) : req_sat;
        samples = SW'(frames) * SW'(ch_eff);
        after   = r_avail - FW'(frames);
    end

    // Index wrap at the effective capacity
    always_comb begin
        rd_inc  = FW'(r_rd_idx) + FW'(1);
        wr_inc  = FW'(r_wr_idx) + FW'(1);
        rd_next = (rd_inc >= cap_eff) ? '0 : AW'(rd_inc);
        wr_next = (wr_inc >= cap_eff) ? '0 : AW'(wr_inc);
    end

    assign o_s_axis_tready = (r_state == oafr_pkg::ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_ready       = !r_out_valid || i_m_axis_tready;
    assign issue           = (r_state == oafr_pkg::ST_READ) && (!r_m_valid || out_ready);
    assign mem_we          = in_xfer && (op == oafr_pkg::OP_PUSH);
    assign mem_re          = issue && !r_bubble;

    // Control next state
    always_comb begin
        n_state    = r_state;
        n_rd_idx   = r_rd_idx;
        n_wr_idx   = r_wr_idx;
        n_fill     = r_fill;
        n_avail    = r_avail;
        n_rem      = r_rem;
        n_finished = r_finished;
        n_left     = r_left;
        n_bubble   = r_bubble;
        n_tmpl     = r_tmpl;

        unique case (r_state)
            oafr_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    case (op)
                        oafr_pkg::OP_PUSH: begin
                            n_wr_idx = wr_next;
                            if (r_fill >= cap_eff) begin
                                // full: drop the oldest, frame count unchanged
                                n_rd_idx = rd_next;
                            end else begin
                                n_fill = r_fill + FW'(1);
                                if ({1'b0, r_rem} + 4'd1 == ch_eff) begin
                                    n_rem   = '0;
                                    n_avail = r_avail + FW'(1);
                                end else begin
                                    n_rem = r_rem + 3'd1;
                                end
                            end
                        end
                        oafr_pkg::OP_READ: begin
                            n_fill   = r_fill - FW'(samples);
                            n_avail  = after;
                            n_bubble = (frames == '0);
                            n_left   = (frames == '0) ? SW'(1) : samples;
                            n_tmpl.sample_valid    = (frames != '0);
                            n_tmpl.last_of_read    = 1'b0;
                            n_tmpl.frames_read     = oafr_pkg::REQ_W'(frames);
                            n_tmpl.frames_buffered = oafr_pkg::FRAMES_W'(after);
                            n_tmpl.stream_finished = r_finished;
                            n_state  = oafr_pkg::ST_READ;
                        end
                        oafr_pkg::OP_FINISH: begin
                            n_finished = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            oafr_pkg::ST_READ: begin
                if (issue) begin
                    if (!r_bubble) begin
                        n_rd_idx = rd_next;
                    end
                    n_left = r_left - SW'(1);
                    if (r_left == SW'(1)) begin
                        n_state = oafr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = oafr_pkg::ST_IDLE;
            end
        endcase

        // Any register write empties the ring
        if (i_cfg_we) begin
            n_rd_idx = '0;
            n_wr_idx = '0;
            n_fill   = '0;
            n_avail  = '0;
            n_rem    = '0;
        end
    end

    // Side information for the result being issued
    always_comb begin
        issue_meta              = r_tmpl;
        issue_meta.last_of_read = (r_left == SW'(1));
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= oafr_pkg::ST_IDLE;
            r_ch       <= oafr_pkg::CH_RESET;
            r_cap      <= oafr_pkg::CAP_RESET;
            r_rd_idx   <= '0;
            r_wr_idx   <= '0;
            r_fill     <= '0;
            r_avail    <= '0;
            r_rem      <= '0;
            r_finished <= 1'b0;
            r_left     <= '0;
            r_bubble   <= 1'b0;
            r_m_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_idx   <= n_rd_idx;
            r_wr_idx   <= n_wr_idx;
            r_fill     <= n_fill;
            r_avail    <= n_avail;
            r_rem      <= n_rem;
            r_finished <= n_finished;
            r_left     <= n_left;
            r_bubble   <= n_bubble;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    oafr_pkg::REG_CHANNELS: r_ch  <= i_cfg_data[oafr_pkg::CH_W-1:0];
                    oafr_pkg::REG_CAPACITY: r_cap <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (issue) begin
                r_m_valid <= 1'b1;
            end else if (out_ready) begin
                r_m_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_m_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_tmpl <= n_tmpl;
        if (issue) begin
            r_m_meta <= issue_meta;
        end
        if (out_ready && r_m_valid) begin
            r_out_meta   <= r_m_meta;
            r_out_sample <= r_m_meta.sample_valid ? r_rd_data : '0;
        end
    end

    // Sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_idx] <= i_s_axis_tdata[oafr_pkg::SAMPLE_W-1:0];
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    // Result port
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_meta.sample_valid;
    assign o_m_axis_tlast  = r_out_meta.last_of_read;
    assign o_m_axis_tdata  = {5'd0,
                              r_out_meta.stream_finished,
                              r_out_meta.frames_buffered,
                              r_out_meta.frames_read,
                              r_out_sample};

    // Fill never exceeds the capacity in use
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= cap_eff)
        else $error("fill count above capacity");

    // Frame count and remainder stay consistent with the fill count
    a_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_avail) * 32'(ch_eff) + 32'(r_rem) == 32'(r_fill))
        else $error("frame count out of step with fill count");

    // An empty-read result is always the last one and reports no frames
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_meta.sample_valid) |->
        (r_out_meta.last_of_read && r_out_meta.frames_read == '0))
        else $error("malformed empty read result");

    // Read sequencing always has work left while in the read state
    a_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == oafr_pkg::ST_READ) |-> (r_left != '0))
        else $error("read state with nothing left to issue");

endmodule
